// ===== rtl/xadpcm_pkg.sv =====
// shared types, constants and helpers for the xa adpcm byte decoder
package xadpcm_pkg;

    localparam int DATA_W     = 8;
    localparam int PARAM_W    = 8;
    localparam int COEF_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int SHIFT_W    = 4;
    localparam int FILT_W     = 2;
    localparam int NUM_FILT   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = DATA_W + PARAM_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 2 * SAMPLE_W;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int COEF_FRAC  = 6;
    localparam int TERM_W     = PROD_W - COEF_FRAC;
    localparam int ACC_W      = TERM_W + 1;
    localparam int SUM_W      = ACC_W + 1;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] RANGE_MAX  = 4'd12;
    localparam logic [3:0] SHIFT_BASE = 4'd12;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    // user bits of the input word
    localparam int USER_SIDE    = 0;
    localparam int USER_RESTART = 1;

    localparam logic signed [COEF_W-1:0] COEF_POS_RST [NUM_FILT] =
        '{8'sd0, 8'sd60, 8'sd115, 8'sd98};
    localparam logic signed [COEF_W-1:0] COEF_NEG_RST [NUM_FILT] =
        '{8'sd0, 8'sd0, -8'sd52, -8'sd55};

    typedef struct packed {
        logic [DATA_W-1:0]  data_byte;
        logic [SHIFT_W-1:0] shift;
        logic [FILT_W-1:0]  filt;
        logic               side;
        logic               restart;
    } item_t;

    typedef struct packed {
        logic  valid;
        logic  full;
        item_t head;
    } q_status_t;

    function automatic logic [SHIFT_W-1:0] range_to_shift(input logic [3:0] range);
        logic [SHIFT_W-1:0] s;
        if (range > RANGE_MAX)
            s = '0;
        else
            s = SHIFT_BASE - range;
        return s;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] saturate(
        input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SUM_W'(SAMPLE_MAX))
            r = SAMPLE_MAX;
        else if (v < SUM_W'(SAMPLE_MIN))
            r = SAMPLE_MIN;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/xadpcm_front.sv =====
// input side: takes words and turns the group parameter into shift and filter
module xadpcm_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [xadpcm_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [xadpcm_pkg::IN_USER_W-1:0] s_tuser,
    input  xadpcm_pkg::q_status_t          q_stat,
    output logic                           push,
    output xadpcm_pkg::item_t              item
);
    import xadpcm_pkg::*;

    logic [PARAM_W-1:0] group_param;

    assign group_param = s_tdata[IN_DATA_W-1:DATA_W];
    assign s_tready    = !q_stat.full;
    assign push        = s_tvalid && !q_stat.full;

    always_comb
    begin
        item.data_byte = s_tdata[DATA_W-1:0];
        item.shift     = range_to_shift(group_param[3:0]);
        item.filt      = group_param[5:4];
        item.side      = s_tuser[USER_SIDE];
        item.restart   = s_tuser[USER_RESTART];
    end

endmodule

// ===== rtl/xadpcm_queue.sv =====
// short queue between front and back
module xadpcm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  xadpcm_pkg::item_t     push_item,
    input  logic                  pop,
    output xadpcm_pkg::q_status_t q_stat
);
    import xadpcm_pkg::*;

    item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign do_push = push && (count_reg != Q_CNT_W'(Q_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.head  = mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/xadpcm_back.sv =====
// decode sequencer: shared multiplier, predictors, coefficients, output register
module xadpcm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [xadpcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [xadpcm_pkg::COEF_W-1:0]     cfg_data,
    input  xadpcm_pkg::q_status_t             q_stat,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [xadpcm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import xadpcm_pkg::*;

    localparam logic [2:0] ST_M1 = 3'd0;
    localparam logic [2:0] ST_M2 = 3'd1;
    localparam logic [2:0] ST_SA = 3'd2;
    localparam logic [2:0] ST_MB = 3'd3;
    localparam logic [2:0] ST_SB = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    item_t                       cur_reg;
    logic signed [COEF_W-1:0]    cpos_reg [NUM_FILT];
    logic signed [COEF_W-1:0]    cneg_reg [NUM_FILT];
    logic signed [SAMPLE_W-1:0]  p1_reg [2];
    logic signed [SAMPLE_W-1:0]  p2_reg [2];
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [SAMPLE_W-1:0]  samp_a_reg;
    logic                        out_valid_reg;
    logic [OUT_DATA_W-1:0]       out_data_reg;

    logic                        side_sel;
    logic [FILT_W-1:0]           filt_sel;
    logic signed [SAMPLE_W-1:0]  p1_sel;
    logic signed [SAMPLE_W-1:0]  p2_sel;
    logic signed [COEF_W-1:0]    cpos_sel;
    logic signed [COEF_W-1:0]    cneg_sel;
    logic signed [SAMPLE_W-1:0]  mul_a;
    logic signed [COEF_W-1:0]    mul_b;
    logic [3:0]                  nib;
    logic signed [SAMPLE_W-1:0]  base;
    logic signed [PROD_W-1:0]    prod_sh;
    logic signed [TERM_W-1:0]    term;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [SUM_W-1:0]     sum;
    logic signed [SAMPLE_W-1:0]  sat;
    logic                        out_load;

    assign side_sel = (state_reg == ST_M1) ? q_stat.head.side : cur_reg.side;
    assign filt_sel = (state_reg == ST_M1) ? q_stat.head.filt : cur_reg.filt;
    assign p1_sel   = p1_reg[side_sel];
    assign p2_sel   = p2_reg[side_sel];
    assign cpos_sel = cpos_reg[filt_sel];
    assign cneg_sel = cneg_reg[filt_sel];

    assign pop      = (state_reg == ST_M1) && q_stat.valid;
    assign out_load = (state_reg == ST_SB) && (!out_valid_reg || m_tready);

    // multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_M1:
            begin
                mul_a = q_stat.head.restart ? '0 : p1_sel;
                mul_b = cpos_sel;
            end
            ST_M2:
            begin
                mul_a = p2_sel;
                mul_b = cneg_sel;
            end
            ST_SA:
            begin
                mul_a = p1_sel;
                mul_b = cneg_sel;
            end
            ST_MB:
            begin
                mul_a = p1_sel;
                mul_b = cpos_sel;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // nibble scaling and accumulation
    always_comb
    begin
        nib      = (state_reg == ST_M2) ? cur_reg.data_byte[3:0] : cur_reg.data_byte[7:4];
        base     = $signed({nib, 12'b0}) >>> cur_reg.shift;
        prod_sh  = prod_reg >>> COEF_FRAC;
        term     = prod_sh[TERM_W-1:0];
        acc_next = ACC_W'(base) + ACC_W'(term);
        sum      = SUM_W'(acc_reg) + SUM_W'(term);
        sat      = saturate(sum);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_M1: if (q_stat.valid) state_next = ST_M2;
            ST_M2: state_next = ST_SA;
            ST_SA: state_next = ST_MB;
            ST_MB: state_next = ST_SB;
            ST_SB: if (out_load) state_next = ST_M1;
            default: state_next = ST_M1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_M1;
            out_valid_reg <= 1'b0;
            p1_reg        <= '{default: '0};
            p2_reg        <= '{default: '0};
            cpos_reg      <= COEF_POS_RST;
            cneg_reg      <= COEF_NEG_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                if (cfg_index[CFG_IDX_W-1])
                    cneg_reg[cfg_index[FILT_W-1:0]] <= cfg_data;
                else
                    cpos_reg[cfg_index[FILT_W-1:0]] <= cfg_data;
            end

            if (pop && q_stat.head.restart)
            begin
                p1_reg <= '{default: '0};
                p2_reg <= '{default: '0};
            end
            else if (state_reg == ST_SA || out_load)
            begin
                p2_reg[cur_reg.side] <= p1_reg[cur_reg.side];
                p1_reg[cur_reg.side] <= sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_stat.head;
        if (state_reg != ST_SB)
            prod_reg <= mul_a * mul_b;
        if (state_reg == ST_M2 || state_reg == ST_MB)
            acc_reg <= acc_next;
        if (state_reg == ST_SA)
            samp_a_reg <= sat;
        if (out_load)
            out_data_reg <= {sat, samp_a_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/xa_adpcm_byte_decoder.sv =====
// top level of the xa adpcm byte decoder
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata: data_byte, group_param; tuser: side, restart
//  m_      | out | m_tvalid/m_tready  | tdata: sample_first, sample_second
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data (coefficient write)
//
// in the decode sequencer a byte makes four passes through the one
// shared 16x8 multiplier plus a final saturate, the two nibbles being dependent
// a two-word queue lets the input take words while the sequencer works
// the output register lets the next byte decode while a result waits
// reset clears predictors, queue and output valid and loads default coefficients
module xa_adpcm_byte_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [xadpcm_pkg::IN_DATA_W-1:0]  s_tdata,   // data_byte, group_param
    input  logic [xadpcm_pkg::IN_USER_W-1:0]  s_tuser,   // side, restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [xadpcm_pkg::OUT_DATA_W-1:0] m_tdata,   // sample_first, sample_second
    input  logic                              cfg_we,
    input  logic [xadpcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [xadpcm_pkg::COEF_W-1:0]     cfg_data
);
    import xadpcm_pkg::*;

    q_status_t q_stat;
    item_t     push_item;
    logic      push;
    logic      pop;

    xadpcm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .item     (push_item)
    );

    xadpcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_stat    (q_stat)
    );

    xadpcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/xadpcm_checker.sv =====
// port-level checks for the xa adpcm byte decoder
module xadpcm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [xadpcm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import xadpcm_pkg::*;

    localparam int PEND_MAX = Q_DEPTH + 2;
    localparam int PEND_W   = $clog2(PEND_MAX + 2);

    logic [PEND_W-1:0] pend_reg;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_acc && !out_acc)
            pend_reg <= pend_reg + 1'b1;
        else if (out_acc && !in_acc)
            pend_reg <= pend_reg - 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == '0 |-> !m_tvalid)
        else $error("result without a pending word");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(PEND_MAX))
        else $error("more words pending than storage allows");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && pend_reg == '0 |=> !m_tvalid)
        else $error("result faster than the decode sequence");

endmodule

bind xa_adpcm_byte_decoder xadpcm_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/xa_adpcm_byte_decoder_tb.sv =====
// self-checking testbench for the xa adpcm byte decoder: directed table then random bytes
module xa_adpcm_byte_decoder_tb;
    import xadpcm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SEG_ITEMS    = 315;
    localparam int NUM_SEGS     = 6;
    localparam int NUM_DIRECTED = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_0, REG_POS_1, REG_POS_2, REG_POS_3,
        REG_NEG_0, REG_NEG_1, REG_NEG_2, REG_NEG_3
    } reg_index_e;

    typedef enum int {
        SET_ALL_MAX, SET_ALL_MIN, SET_RANDOM, SET_SPLIT_EXTREME, SET_DEFAULT
    } coef_set_e;

    typedef struct {
        logic [7:0]         data_byte;
        logic [7:0]         group_param;
        logic               side;
        logic               restart;
        bit                 typed;
        logic signed [15:0] exp_first;
        logic signed [15:0] exp_second;
    } stim_row_t;

    typedef struct {
        logic signed [15:0] first;
        logic signed [15:0] second;
    } pcm_pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // data_byte, group_param
    logic [IN_USER_W-1:0]  s_tuser;   // side, restart
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // sample_first, sample_second
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COEF_W-1:0]     cfg_data;

    logic signed [7:0]  coef_pos [4];
    logic signed [7:0]  coef_neg [4];
    logic signed [15:0] hist_one [2];
    logic signed [15:0] hist_two [2];

    pcm_pair_t pending_pcm [$];

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int mismatch_count;
    int words_sent;
    int words_checked;
    int coef_sets;

    stim_row_t directed [NUM_DIRECTED] = '{
        '{8'h7F, 8'h0C, 1'b0, 1'b1, 1'b1, -16'sd4096, 16'sd28672},
        '{8'h78, 8'h00, 1'b0, 1'b0, 1'b1, -16'sd8, 16'sd7},
        '{8'h80, 8'h0F, 1'b1, 1'b0, 1'b1, 16'sd0, -16'sd32768},
        '{8'h11, 8'hCC, 1'b1, 1'b0, 1'b1, 16'sd4096, 16'sd4096},
        '{8'h08, 8'h0D, 1'b0, 1'b0, 1'b1, -16'sd32768, 16'sd0},
        '{8'h00, 8'h0E, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0},
        '{8'h77, 8'h0C, 1'b0, 1'b1, 1'b1, 16'sd28672, 16'sd28672},
        '{8'h77, 8'h2C, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h77, 8'h3C, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h12, 8'h15, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h88, 8'h0C, 1'b1, 1'b1, 1'b1, -16'sd32768, -16'sd32768},
        '{8'h88, 8'h2C, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h99, 8'h3B, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h34, 8'h26, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h5A, 8'h1A, 1'b1, 1'b1, 1'b0, 16'sd0, 16'sd0},
        '{8'hA5, 8'h31, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'hF0, 8'hE9, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0},
        '{8'h0F, 8'h23, 1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0}
    };

    xa_adpcm_byte_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] decode_code(input logic [3:0] code,
                                                       input logic [3:0] shift,
                                                       input logic [1:0] filt,
                                                       input logic sd);
        logic signed [15:0] placed;
        int                 base;
        int                 sum;
        placed = {code, 12'h000};
        base   = placed;
        sum    = (base >>> shift)
               + ((int'(hist_one[sd]) * int'(coef_pos[filt])) >>> 6)
               + ((int'(hist_two[sd]) * int'(coef_neg[filt])) >>> 6);
        if (sum > int'(SAMPLE_MAX))
            sum = SAMPLE_MAX;
        else if (sum < int'(SAMPLE_MIN))
            sum = SAMPLE_MIN;
        hist_two[sd] = hist_one[sd];
        hist_one[sd] = sum[15:0];
        return sum[15:0];
    endfunction

    function automatic pcm_pair_t decode_byte(input logic [7:0] data_byte,
                                              input logic [7:0] group_param,
                                              input logic sd,
                                              input logic restart);
        pcm_pair_t  pcm;
        logic [3:0] range;
        logic [3:0] shift;
        range = group_param[3:0];
        shift = (range > 4'd12) ? 4'd0 : 4'd12 - range;
        if (restart)
        begin
            hist_one = '{16'sd0, 16'sd0};
            hist_two = '{16'sd0, 16'sd0};
        end
        pcm.first  = decode_code(data_byte[3:0], shift, group_param[5:4], sd);
        pcm.second = decode_code(data_byte[7:4], shift, group_param[5:4], sd);
        return pcm;
    endfunction

    task automatic note_mismatch(input string what, input int expv, input int gotv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, expv, gotv);
    endtask

    // checks each output word against the oldest predicted sample pair
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            pcm_pair_t want;
            if (pending_pcm.size() == 0)
            begin
                note_mismatch("unexpected word", 0, int'(m_tdata));
            end
            else
            begin
                want = pending_pcm.pop_front();
                words_checked++;
                if (m_tdata[15:0] !== want.first)
                    note_mismatch("sample_first", want.first, $signed(m_tdata[15:0]));
                if (m_tdata[31:16] !== want.second)
                    note_mismatch("sample_second", want.second, $signed(m_tdata[31:16]));
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     pending_pcm.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] data_byte, input logic [7:0] group_param,
                             input logic sd, input logic restart, input bit typed,
                             input logic signed [15:0] exp_first,
                             input logic signed [15:0] exp_second);
        pcm_pair_t pcm;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        s_tdata  <= {group_param, data_byte};
        s_tuser  <= {restart, sd};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pcm = decode_byte(data_byte, group_param, sd, restart);
        if (typed)
        begin
            pcm.first  = exp_first;
            pcm.second = exp_second;
        end
        pending_pcm.push_back(pcm);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pcm.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_e idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx <= REG_POS_3)
            coef_pos[idx - REG_POS_0] = value;
        else
            coef_neg[idx - REG_NEG_0] = value;
    endtask

    task automatic load_coef_set(input coef_set_e kind);
        logic [7:0] pos_val;
        logic [7:0] neg_val;
        for (int f = 0; f < NUM_FILT; f++)
        begin
            case (kind)
                SET_ALL_MAX:       begin pos_val = 8'h7F; neg_val = 8'h7F; end
                SET_ALL_MIN:       begin pos_val = 8'h80; neg_val = 8'h80; end
                SET_SPLIT_EXTREME: begin pos_val = 8'h7F; neg_val = 8'h80; end
                SET_DEFAULT:       begin pos_val = COEF_POS_RST[f]; neg_val = COEF_NEG_RST[f]; end
                default:
                begin
                    pos_val = 8'($urandom_range(0, 255));
                    neg_val = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(reg_index_e'(REG_POS_0 + f), pos_val);
            write_reg(reg_index_e'(REG_NEG_0 + f), neg_val);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        coef_sets++;
    endtask

    initial
    begin
        coef_set_e seg_sets [NUM_SEGS];
        seg_sets       = '{SET_ALL_MAX, SET_RANDOM, SET_ALL_MIN,
                           SET_SPLIT_EXTREME, SET_RANDOM, SET_DEFAULT};
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        mismatch_count = 0;
        words_sent     = 0;
        words_checked  = 0;
        coef_sets      = 0;
        send_idle_pct  = 7;
        recv_stall_pct = 59;
        for (int f = 0; f < NUM_FILT; f++)
        begin
            coef_pos[f] = COEF_POS_RST[f];
            coef_neg[f] = COEF_NEG_RST[f];
        end
        hist_one = '{16'sd0, 16'sd0};
        hist_two = '{16'sd0, 16'sd0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].data_byte, directed[i].group_param, directed[i].side,
                      directed[i].restart, directed[i].typed, directed[i].exp_first,
                      directed[i].exp_second);

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            // coefficients change only with the pipeline drained
            wait_idle();
            load_coef_set(seg_sets[seg]);
            case (seg / 2)
                0:       begin send_idle_pct = 7;  recv_stall_pct = 59; end
                1:       begin send_idle_pct = 59; recv_stall_pct = 7;  end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
                send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), $urandom_range(0, 99) < 3,
                          1'b0, 16'sd0, 16'sd0);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d sample pairs over %0d coefficient sets",
                 words_sent, words_checked, coef_sets);
        $display("both sides, all ranges and filters, restarts and saturation exercised");
        if (mismatch_count == 0 && pending_pcm.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== xa_adpcm_byte_decoder.f =====
rtl/xadpcm_pkg.sv
rtl/xadpcm_front.sv
rtl/xadpcm_queue.sv
rtl/xadpcm_back.sv
rtl/xa_adpcm_byte_decoder.sv
rtl/xadpcm_checker.sv
bench/xa_adpcm_byte_decoder_tb.sv
